@@ hw/rtl/device_pointer_scan_classifier_macros.svh @@
// assertion macros for the device pointer scan classifier
`ifndef DEVICE_POINTER_SCAN_CLASSIFIER_MACROS_SVH
`define DEVICE_POINTER_SCAN_CLASSIFIER_MACROS_SVH

// check that a implies b on the same edge
`define DPSC_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// check that a implies b on the next edge
`define DPSC_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/dpsc_pkg.sv @@
// shared types and constants of the device pointer scan classifier
package dpsc_pkg;

   localparam logic [2:0] MODE_ADD_AS    = 3'd0;
   localparam logic [2:0] MODE_DROP_AS   = 3'd1;
   localparam logic [2:0] MODE_ADD_BUF   = 3'd2;
   localparam logic [2:0] MODE_SET_SIZE  = 3'd3;
   localparam logic [2:0] MODE_DROP_BUF  = 3'd4;
   localparam logic [2:0] MODE_SCAN      = 3'd5;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_AS   = 2'd1;
   localparam logic [1:0] KIND_BUF  = 2'd2;

   localparam logic CSR_ENABLE_SCAN = 1'b0;
   localparam logic CSR_WINDOW_SLACK = 1'b1;

   localparam logic [63:0] ADDR_ALL_ONES = '1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_WALK  = 8'b0000_0010,
      ST_SIZE  = 8'b0000_0100,
      ST_FIN   = 8'b0000_1000,
      ST_WRITE = 8'b0001_0000,
      ST_OUT   = 8'b0010_0000
   } state_type;

endpackage

@@ hw/rtl/device_pointer_scan_classifier.sv @@
// device pointer scan classifier: three tables in memories walked one entry a cycle
//
//   channel  direction  ports
//   req      in         req_valid/req_ready, mode address handle buffer_size word_index
//   rsp      out        rsp_valid/rsp_ready, match_kind byte_offset status
//   csr      in         csr_write_enable, csr_index, csr_write_data
//
// one table walk reads each entry of the table in turn; a buffer drop walks the size table then
// the base table, a scan up to the as, base and size tables, a zero word or unused mode none
// the rate is set by the single read port of each table memory
// reset clears valid bits and bounds at once; no clearing pass
// a stalled result holds in the output register; the next item waits for it to drain
`include "device_pointer_scan_classifier_macros.svh"
module device_pointer_scan_classifier #(
   parameter int AS_ENTRIES = 64,
   parameter int BUFFER_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [63:0] req_address,
   input  logic [63:0] req_handle,
   input  logic [63:0] req_buffer_size,
   input  logic [28:0] req_word_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_match_kind,
   output logic [31:0] rsp_byte_offset,
   output logic        rsp_status,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import dpsc_pkg::*;

   localparam int AW = (AS_ENTRIES > 1) ? $clog2(AS_ENTRIES) : 1;
   localparam int BW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
   localparam int IW = (AW > BW) ? AW : BW;
   localparam logic [IW:0] AS_LAST = (IW + 1)'(AS_ENTRIES - 1);
   localparam logic [IW:0] BUF_LAST = (IW + 1)'(BUFFER_ENTRIES - 1);

   // memories: key and value per table
   logic [63:0] as_key_mem [AS_ENTRIES];
   logic [63:0] as_val_mem [AS_ENTRIES];
   logic [63:0] bb_key_mem [BUFFER_ENTRIES];
   logic [63:0] bb_val_mem [BUFFER_ENTRIES];
   logic [63:0] sz_key_mem [BUFFER_ENTRIES];
   logic [63:0] sz_val_mem [BUFFER_ENTRIES];
   logic [AS_ENTRIES-1:0] as_valid_ff;
   logic [BUFFER_ENTRIES-1:0] bb_valid_ff, sz_valid_ff;

   logic [63:0] rd_key_ff, rd_val_ff;
   logic [1:0]  rd_tab_ff;
   logic        rd_live_ff;
   logic [IW-1:0] rd_idx_ff;

   state_type state_ff, state_in;
   logic [2:0]  mode_ff;
   logic [1:0]  phase_ff, phase_in; // 0 as/main table, 1 bases, 2 sizes
   logic [63:0] addr_ff, hdl_ff, size_ff;
   logic [28:0] widx_ff;
   logic [IW:0] cnt_ff, cnt_in;
   logic        hit_ff, hit_in, fre_ff, fre_in, best_ok_ff, best_ok_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in, fre_idx_ff, fre_idx_in;
   logic [63:0] best_base_ff, best_base_in, best_hdl_ff, best_hdl_in;
   logic        szhit_ff, szhit_in, bbhit_ff, bbhit_in;
   logic [IW-1:0] bbidx_ff, bbidx_in;
   logic [63:0] szval_ff, szval_in;
   logic [1:0]  kind_ff, kind_in;
   logic [63:0] low_ff, high_ff;
   logic        en_ff;
   logic [31:0] slack_ff;
   logic        rv_ff;
   logic [1:0]  okind_ff;
   logic [31:0] ooff_ff;
   logic        ostat_ff;

   // read address and table
   logic [IW:0] rd_cnt;
   logic [1:0]  rd_tab;
   logic        rd_en;
   logic [IW:0] tab_last;
   logic [IW-1:0] ridx;

   always_comb begin
      unique case (phase_ff)
         2'd0: rd_tab = (mode_ff == MODE_ADD_AS || mode_ff == MODE_DROP_AS ||
                         mode_ff == MODE_SCAN) ? 2'd0 :
                        (mode_ff == MODE_SET_SIZE) ? 2'd2 : 2'd1;
         2'd1: rd_tab = 2'd1;
         default: rd_tab = 2'd2;
      endcase
      tab_last = (rd_tab == 2'd0) ? AS_LAST : BUF_LAST;
   end
   assign rd_cnt = cnt_ff;
   assign ridx = rd_cnt[IW-1:0];
   assign rd_en = (state_ff == ST_WALK);

   always_ff @(posedge clock) begin
      rd_live_ff <= 1'b0;
      if (rd_en) begin
         rd_tab_ff <= rd_tab;
         rd_idx_ff <= ridx;
         rd_live_ff <= 1'b1;
         case (rd_tab)
            2'd0: begin
               rd_key_ff <= as_key_mem[AW'(ridx)];
               rd_val_ff <= as_val_mem[AW'(ridx)];
            end
            2'd1: begin
               rd_key_ff <= bb_key_mem[BW'(ridx)];
               rd_val_ff <= bb_val_mem[BW'(ridx)];
            end
            default: begin
               rd_key_ff <= sz_key_mem[BW'(ridx)];
               rd_val_ff <= sz_val_mem[BW'(ridx)];
            end
         endcase
      end
   end

   logic rd_valid_bit;
   always_comb begin
      case (rd_tab_ff)
         2'd0: rd_valid_bit = as_valid_ff[AW'(rd_idx_ff)];
         2'd1: rd_valid_bit = bb_valid_ff[BW'(rd_idx_ff)];
         default: rd_valid_bit = sz_valid_ff[BW'(rd_idx_ff)];
      endcase
   end

   // search key: address for adds and scans, handle for drops and sizes, best base handle in a scan's size walk
   logic [63:0] cmp_key, cmp_slot;
   logic        use_val;
   logic [64:0] top_sum;
   logic        over_top;
   always_comb begin
      use_val = (mode_ff == MODE_DROP_AS) || (mode_ff == MODE_DROP_BUF && rd_tab_ff == 2'd1);
      cmp_key = (mode_ff == MODE_SET_SIZE || mode_ff == MODE_DROP_BUF) ? hdl_ff :
                (mode_ff == MODE_DROP_AS) ? hdl_ff : addr_ff;
      if (mode_ff == MODE_SCAN && rd_tab_ff == 2'd2)
         cmp_key = best_hdl_ff;
      cmp_slot = use_val ? rd_val_ff : rd_key_ff;
      top_sum = {1'b0, high_ff} + {33'd0, slack_ff};
      over_top = !top_sum[64] && (addr_ff > top_sum[63:0]);
   end

   logic match_now;
   assign match_now = rd_live_ff && rd_valid_bit && (cmp_slot == cmp_key);

   logic walk_done;
   assign walk_done = (cnt_ff == tab_last);

   logic [64:0] top_chk;
   assign top_chk = {1'b0, best_base_ff} + {1'b0, szval_ff};

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      fre_in = fre_ff;
      fre_idx_in = fre_idx_ff;
      best_ok_in = best_ok_ff;
      best_base_in = best_base_ff;
      best_hdl_in = best_hdl_ff;
      szhit_in = szhit_ff;
      szval_in = szval_ff;
      bbhit_in = bbhit_ff;
      bbidx_in = bbidx_ff;
      kind_in = kind_ff;
      // fold the registered entry of the previous cycle
      if (rd_live_ff) begin
         if (mode_ff == MODE_SCAN && rd_tab_ff == 2'd1) begin
            if (rd_valid_bit && rd_key_ff <= addr_ff &&
                (!best_ok_in || rd_key_ff > best_base_in)) begin
               best_ok_in = 1'b1;
               best_base_in = rd_key_ff;
               best_hdl_in = rd_val_ff;
            end
         end else if (mode_ff == MODE_DROP_BUF && rd_tab_ff == 2'd2) begin
            if (match_now && !szhit_in) begin
               szhit_in = 1'b1;
               bbidx_in = rd_idx_ff;
            end
         end else if (mode_ff == MODE_SCAN && rd_tab_ff == 2'd2) begin
            if (match_now && !szhit_in) begin
               szhit_in = 1'b1;
               szval_in = rd_val_ff;
            end
         end else if (mode_ff == MODE_DROP_BUF && rd_tab_ff == 2'd1) begin
            if (match_now && !bbhit_in) begin
               bbhit_in = 1'b1;
               hit_idx_in = rd_idx_ff;
            end
         end else begin
            if (match_now && !hit_in) begin
               hit_in = 1'b1;
               hit_idx_in = rd_idx_ff;
            end
            if (!rd_valid_bit && !fre_in) begin
               fre_in = 1'b1;
               fre_idx_in = rd_idx_ff;
            end
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cnt_in = '0;
               phase_in = 2'd0;
               hit_in = 1'b0;
               fre_in = 1'b0;
               best_ok_in = 1'b0;
               szhit_in = 1'b0;
               bbhit_in = 1'b0;
               kind_in = KIND_NONE;
               if (req_mode == MODE_SCAN && req_address == '0)
                  state_in = ST_WRITE;
               else if (req_mode == MODE_DROP_BUF) begin
                  phase_in = 2'd2;
                  state_in = ST_WALK;
               end else if (req_mode <= MODE_SCAN)
                  state_in = ST_WALK;
               else
                  state_in = ST_WRITE;
            end
         end
         ST_WALK: begin
            if (walk_done)
               state_in = ST_FIN;
            else
               cnt_in = cnt_ff + 1'b1;
         end
         ST_FIN: begin
            // last entry folded this cycle; decide next phase
            state_in = ST_WRITE;
            cnt_in = '0;
            if (mode_ff == MODE_SCAN && phase_ff == 2'd0) begin
               if (hit_in) kind_in = KIND_AS;
               else if (addr_ff >= low_ff && !over_top && en_ff) begin
                  phase_in = 2'd1;
                  state_in = ST_WALK;
               end
            end else if (mode_ff == MODE_SCAN && phase_ff == 2'd1) begin
               if (best_ok_in) begin
                  if (best_base_in == addr_ff) kind_in = KIND_BUF;
                  else begin
                     phase_in = 2'd2;
                     state_in = ST_WALK;
                  end
               end
            end else if (mode_ff == MODE_SCAN) begin
               state_in = ST_SIZE;
            end else if (mode_ff == MODE_DROP_BUF && phase_ff == 2'd2) begin
               phase_in = 2'd1;
               state_in = ST_WALK;
            end
         end
         ST_SIZE: begin
            if (szhit_ff && (top_chk[64] || addr_ff <= top_chk[63:0])) kind_in = KIND_BUF;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE) && (!rv_ff || rsp_ready);

   logic refuse;
   assign refuse = !hit_ff && !fre_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_ready) begin
         mode_ff <= req_mode;
         addr_ff <= req_address;
         hdl_ff <= req_handle;
         size_ff <= req_buffer_size;
         widx_ff <= req_word_index;
      end
      hit_idx_ff <= hit_idx_in;
      fre_idx_ff <= fre_idx_in;
      best_base_ff <= best_base_in;
      best_hdl_ff <= best_hdl_in;
      szval_ff <= szval_in;
      bbidx_ff <= bbidx_in;
      if (state_ff == ST_WRITE) begin
         unique case (mode_ff)
            MODE_ADD_AS: if (!refuse) begin
               as_key_mem[AW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= addr_ff;
               as_val_mem[AW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= hdl_ff;
            end
            MODE_ADD_BUF: if (!refuse) begin
               bb_key_mem[BW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= addr_ff;
               bb_val_mem[BW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= hdl_ff;
            end
            MODE_SET_SIZE: if (!refuse) begin
               sz_key_mem[BW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= hdl_ff;
               sz_val_mem[BW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= size_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 2'd0;
         cnt_ff <= '0;
         hit_ff <= 1'b0;
         fre_ff <= 1'b0;
         best_ok_ff <= 1'b0;
         szhit_ff <= 1'b0;
         bbhit_ff <= 1'b0;
         kind_ff <= KIND_NONE;
         as_valid_ff <= '0;
         bb_valid_ff <= '0;
         sz_valid_ff <= '0;
         low_ff <= ADDR_ALL_ONES;
         high_ff <= '0;
         en_ff <= 1'b1;
         slack_ff <= 32'd268435456;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         hit_ff <= hit_in;
         fre_ff <= fre_in;
         best_ok_ff <= best_ok_in;
         szhit_ff <= szhit_in;
         bbhit_ff <= bbhit_in;
         kind_ff <= kind_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ENABLE_SCAN: en_ff <= csr_write_data[0];
               CSR_WINDOW_SLACK: slack_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && (!rv_ff || rsp_ready)) rv_ff <= 1'b1;
         else if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         if (state_ff == ST_WRITE) begin
            unique case (mode_ff)
               MODE_ADD_AS: if (!refuse) as_valid_ff[AW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= 1'b1;
               MODE_DROP_AS: if (hit_ff) as_valid_ff[AW'(hit_idx_ff)] <= 1'b0;
               MODE_ADD_BUF: if (!refuse) begin
                  bb_valid_ff[BW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= 1'b1;
                  if (addr_ff < low_ff) low_ff <= addr_ff;
                  if (addr_ff > high_ff) high_ff <= addr_ff;
               end
               MODE_SET_SIZE: if (!refuse) sz_valid_ff[BW'(hit_ff ? hit_idx_ff : fre_idx_ff)] <= 1'b1;
               MODE_DROP_BUF: begin
                  if (szhit_ff) sz_valid_ff[BW'(bbidx_ff)] <= 1'b0;
                  if (bbhit_ff) bb_valid_ff[BW'(hit_idx_ff)] <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rv_ff || rsp_ready)) begin
         okind_ff <= (mode_ff == MODE_SCAN) ? kind_ff : KIND_NONE;
         ooff_ff <= (mode_ff == MODE_SCAN) ? {widx_ff, 3'b000} : 32'd0;
         ostat_ff <= (mode_ff == MODE_ADD_AS || mode_ff == MODE_ADD_BUF ||
                      mode_ff == MODE_SET_SIZE) && refuse;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_match_kind = okind_ff;
   assign rsp_byte_offset = ooff_ff;
   assign rsp_status = ostat_ff;

   `DPSC_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `DPSC_ASSERT_NEXT(a_accept_leaves, clock, reset, req_valid && req_ready, state_ff != ST_IDLE)
   `DPSC_ASSERT_IMP(a_kind_range, clock, reset, rsp_valid, rsp_match_kind != 2'd3)
   `DPSC_ASSERT_IMP(a_bounds, clock, reset, bb_valid_ff != '0, low_ff <= high_ff)
endmodule

@@ tb/device_pointer_scan_classifier_test.sv @@
// self-checking testbench for the device pointer scan classifier
module device_pointer_scan_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dpsc_pkg::*;

   localparam int ENTRIES = 64;
   localparam int LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] address;
      logic [63:0] handle;
      logic [63:0] size;
      logic [28:0] index;
   } request_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] offset;
      logic        status;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_mode = '0;
   logic [63:0] req_address = '0, req_handle = '0, req_buffer_size = '0;
   logic [28:0] req_word_index = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_match_kind;
   logic [31:0] rsp_byte_offset;
   logic rsp_status;
   logic csr_write_enable = 0;
   logic [0:0] csr_index = '0;
   logic [31:0] csr_write_data = '0;

   device_pointer_scan_classifier i_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [63:0] as_key [ENTRIES], as_val [ENTRIES];
   logic        as_ok [ENTRIES];
   logic [63:0] base_key [ENTRIES], base_val [ENTRIES];
   logic        base_ok [ENTRIES];
   logic [63:0] size_key [ENTRIES], size_val [ENTRIES];
   logic        size_ok [ENTRIES];
   logic [63:0] low_addr, high_addr;
   logic        scan_on;
   logic [31:0] slack;

   request_type pending_items[$];
   verdict_type expected_verdicts[$];
   int failures = 0;
   int send_idle = 0, recv_idle = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;
   logic [63:0] addr_pool[$];

   function automatic int find_key(ref logic [63:0] k [ENTRIES], ref logic ok [ENTRIES],
                                   input logic [63:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (ok[i] && k[i] == key) return i;
      return -1;
   endfunction

   function automatic logic put_entry(ref logic [63:0] k [ENTRIES], ref logic [63:0] v [ENTRIES],
                                      ref logic ok [ENTRIES], input logic [63:0] key,
                                      input logic [63:0] val);
      int slot;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (ok[i] && k[i] == key) begin
            v[i] = val;
            return 0;
         end
         if (!ok[i] && slot < 0) slot = i;
      end
      if (slot < 0) return 1;
      k[slot] = key;
      v[slot] = val;
      ok[slot] = 1;
      return 0;
   endfunction

   function automatic void drop_by_value(ref logic [63:0] v [ENTRIES], ref logic ok [ENTRIES],
                                         input logic [63:0] val);
      for (int i = 0; i < ENTRIES; i++)
         if (ok[i] && v[i] == val) begin
            ok[i] = 0;
            return;
         end
   endfunction

   function automatic logic [1:0] classify_word(logic [63:0] w);
      int best, s;
      logic [64:0] top;
      best = -1;
      if (w == 0) return KIND_NONE;
      if (find_key(as_key, as_ok, w) >= 0) return KIND_AS;
      if (w < low_addr) return KIND_NONE;
      top = {1'b0, high_addr} + slack;
      if ({1'b0, w} > top) return KIND_NONE;
      if (!scan_on) return KIND_NONE;
      for (int i = 0; i < ENTRIES; i++)
         if (base_ok[i] && base_key[i] <= w && (best < 0 || base_key[i] > base_key[best]))
            best = i;
      if (best < 0) return KIND_NONE;
      if (base_key[best] == w) return KIND_BUF;
      s = find_key(size_key, size_ok, base_val[best]);
      if (s < 0) return KIND_NONE;
      top = {1'b0, base_key[best]} + size_val[s];
      if ({1'b0, w} > top) return KIND_NONE;
      return KIND_BUF;
   endfunction

   function automatic verdict_type classify_item(request_type r);
      verdict_type v;
      int s;
      v = '0;
      case (r.mode)
         MODE_ADD_AS: v.status = put_entry(as_key, as_val, as_ok, r.address, r.handle);
         MODE_DROP_AS: drop_by_value(as_val, as_ok, r.handle);
         MODE_ADD_BUF: begin
            v.status = put_entry(base_key, base_val, base_ok, r.address, r.handle);
            if (!v.status) begin
               if (r.address < low_addr) low_addr = r.address;
               if (r.address > high_addr) high_addr = r.address;
            end
         end
         MODE_SET_SIZE: v.status = put_entry(size_key, size_val, size_ok, r.handle, r.size);
         MODE_DROP_BUF: begin
            s = find_key(size_key, size_ok, r.handle);
            if (s >= 0) size_ok[s] = 0;
            drop_by_value(base_val, base_ok, r.handle);
         end
         MODE_SCAN: begin
            v.kind = classify_word(r.address);
            v.offset = {r.index, 3'b000};
         end
         default: ;
      endcase
      return v;
   endfunction

   function automatic void enqueue(request_type r);
      pending_items.insert(pending_items.size(), r);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
            request_type r;
            r = pending_items.pop_front();
            expected_verdicts.insert(expected_verdicts.size(), classify_item(r));
            req_valid <= 1;
            req_mode <= r.mode;
            req_address <= r.address;
            req_handle <= r.handle;
            req_buffer_size <= r.size;
            req_word_index <= r.index;
         end else begin
            req_valid <= 0;
         end
      end
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      failures++;
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               verdict_type e;
               e = expected_verdicts.pop_front();
               if (rsp_match_kind !== e.kind) report_mismatch("match_kind", rsp_match_kind, e.kind);
               if (rsp_byte_offset !== e.offset)
                  report_mismatch("byte_offset", rsp_byte_offset, e.offset);
               if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [63:0] pick_addr();
      if (addr_pool.size() > 0 && $urandom_range(3) != 0)
         return addr_pool[$urandom_range(addr_pool.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_handle();
      if ($urandom_range(3) != 0) return 64'(1 + $urandom_range(40));
      return {$urandom, $urandom};
   endfunction

   function automatic request_type make_item(logic [2:0] m, logic [63:0] a, logic [63:0] h,
                                             logic [63:0] s);
      request_type r;
      r.mode = m;
      r.address = a;
      r.handle = h;
      r.size = s;
      r.index = 29'($urandom);
      return r;
   endfunction

   function automatic request_type random_item();
      int pick;
      logic [63:0] base, a;
      pick = $urandom_range(99);
      base = 64'h0000_7f00_0000_0000 + (64'($urandom_range(255)) << 12);
      if (pick < 8) return make_item(MODE_ADD_AS, pick_addr(), pick_handle(), 0);
      if (pick < 12) return make_item(MODE_DROP_AS, 0, pick_handle(), 0);
      if (pick < 26) begin
         addr_pool.insert(addr_pool.size(), base);
         return make_item(MODE_ADD_BUF, base, pick_handle(), 0);
      end
      if (pick < 38) return make_item(MODE_SET_SIZE, 0, pick_handle(),
                                      $urandom_range(5) == 0 ? {$urandom, $urandom}
                                                             : 64'($urandom_range(8192)));
      if (pick < 44) return make_item(MODE_DROP_BUF, 0, pick_handle(), 0);
      if (pick < 97) begin
         a = pick_addr();
         case ($urandom_range(4))
            0: a = a + $urandom_range(9000);
            1: a = a - $urandom_range(64);
            2: a = {$urandom, $urandom};
            default: ;
         endcase
         return make_item(MODE_SCAN, a, {$urandom, $urandom}, {$urandom, $urandom});
      end
      return make_item(3'($urandom_range(6, 7)), {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom});
   endfunction

   task automatic wait_drained(int extra);
      while (pending_items.size() > 0 || expected_verdicts.size() > 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_ENABLE_SCAN) scan_on = data[0];
      else slack = data;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         as_ok[i] = 0;
         base_ok[i] = 0;
         size_ok[i] = 0;
      end
      low_addr = ADDR_ALL_ONES;
      high_addr = 0;
      scan_on = 1;
      slack = 32'h1000_0000;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: extremes and special cases
      send_idle = 0;
      recv_idle = 0;
      enqueue(make_item(MODE_SCAN, 64'h1000, 0, 0));
      enqueue(make_item(MODE_ADD_AS, ADDR_ALL_ONES, ADDR_ALL_ONES, 0));
      enqueue(make_item(MODE_ADD_AS, ADDR_ALL_ONES, 7, 0));
      enqueue(make_item(MODE_ADD_BUF, 64'h1000, 5, 0));
      enqueue(make_item(MODE_ADD_BUF, 64'hffff_ffff_ffff_0000, 6, 0));
      enqueue(make_item(MODE_SET_SIZE, 0, 5, 64'h100));
      enqueue(make_item(MODE_SET_SIZE, 0, 6, ADDR_ALL_ONES));
      enqueue(make_item(MODE_SET_SIZE, 0, 5, 64'h200));
      enqueue(make_item(MODE_SCAN, 0, 0, 0));
      enqueue(make_item(MODE_SCAN, ADDR_ALL_ONES, 0, 0));
      enqueue(make_item(MODE_SCAN, 64'h1000, 0, 0));
      enqueue(make_item(MODE_SCAN, 64'h1200, 0, 0));
      enqueue(make_item(MODE_SCAN, 64'h1201, 0, 0));
      enqueue(make_item(MODE_SCAN, 64'hfff, 0, 0));
      enqueue(make_item(MODE_SCAN, 64'hffff_ffff_ffff_fff8, 0, 0));
      enqueue(make_item(MODE_DROP_AS, 0, 7, 0));
      enqueue(make_item(MODE_DROP_AS, 0, 99, 0));
      enqueue(make_item(MODE_DROP_BUF, 0, 6, 0));
      enqueue(make_item(MODE_SCAN, 64'hffff_ffff_ffff_0000, 0, 0));
      enqueue(make_item(3'd6, ADDR_ALL_ONES, ADDR_ALL_ONES, ADDR_ALL_ONES));
      enqueue(make_item(3'd7, 0, 0, 0));
      begin
         request_type r;
         r = make_item(MODE_SCAN, 64'h1100, 0, 0);
         r.index = '1;
         enqueue(r);
      end
      // fill the tables to overflow
      for (int i = 0; i < 66; i++) begin
         enqueue(make_item(MODE_ADD_AS, 64'h5000 + 64'(i), 64'(200 + i), 0));
         enqueue(make_item(MODE_ADD_BUF, 64'h9_0000 + 64'(i) * 64, 64'(300 + i), 0));
         enqueue(make_item(MODE_SET_SIZE, 0, 64'(300 + i), 64'(i)));
      end
      enqueue(make_item(MODE_SCAN, 64'h9_0020, 0, 0));
      wait_drained(300);

      // empty the tables again
      for (int i = 0; i < 66; i++) begin
         enqueue(make_item(MODE_DROP_AS, 0, 64'(200 + i), 0));
         enqueue(make_item(MODE_DROP_BUF, 0, 64'(300 + i), 0));
      end
      enqueue(make_item(MODE_DROP_AS, 0, ADDR_ALL_ONES, 0));
      enqueue(make_item(MODE_DROP_BUF, 0, 5, 0));
      wait_drained(300);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_csr(CSR_WINDOW_SLACK, 0); write_csr(CSR_ENABLE_SCAN, 1); end
            1: write_csr(CSR_WINDOW_SLACK, '1);
            2: write_csr(CSR_ENABLE_SCAN, 0);
            3: begin write_csr(CSR_ENABLE_SCAN, 1); write_csr(CSR_WINDOW_SLACK, $urandom); end
            4: write_csr(CSR_WINDOW_SLACK, 32'h1000_0000);
            default: write_csr(CSR_WINDOW_SLACK, $urandom_range(65535));
         endcase
         send_idle = (phase < 2) ? 22 : (phase < 4) ? 83 : 0;
         recv_idle = (phase < 2) ? 83 : (phase < 4) ? 22 : 0;
         if (phase == 4) hold_cycles = 3000;
         for (int i = 0; i < 260; i++) enqueue(random_item());
         wait_drained(300);
      end
      if (failures == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dpsc_pkg.sv
hw/rtl/device_pointer_scan_classifier.sv
tb/device_pointer_scan_classifier_test.sv
